FILE: hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the stereo feedback delay: register indexes,
// routing modes and the per-item control strobes sent to the lanes and router.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // width of the delay registers
   localparam int DELAY_BITS = 17;
   // width of the register index on the configuration channel
   localparam int CSR_INDEX_BITS = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_LEFT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_RIGHT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMOOTH_COEFF   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_LEFT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_RIGHT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROUTE_MODE     = 3'd5;

   // feedback routing
   typedef enum logic [1:0] {
      ROUTE_STEREO    = 2'd0,
      ROUTE_CROSS     = 2'd1,
      ROUTE_MONO      = 2'd2,
      ROUTE_PING_PONG = 2'd3
   } route_mode_type;

   // per-cycle strobes of the item sequencer
   typedef struct packed {
      logic read_en;    // issue the delay line read
      logic prod_en;    // register the smoothing product
      logic smooth_en;  // update smoother, latch feedback operands
      logic feed_en;    // register the feedback products
      logic write_en;   // write the delay line and advance the pointer
      logic clear;      // write zero instead of the routed value
   } lane_ctrl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/sfd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_lane
// One channel of the delay: circular delay memory, write pointer, read
// address generation and the one-pole feedback smoother.
// ----------------------------------------------------------------------------
module sfd_lane #(
   parameter int LINE_DEPTH  = 131072,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 16,
   parameter int ADDR_BITS   = 17
) (
   input  wire                          clock,
   input  wire                          reset,
   input  sfd_pkg::lane_ctrl_type       ctrl,
   input  wire        [ADDR_BITS-1:0]   delay,
   input  wire        [COEF_BITS-1:0]   coeff,
   input  wire signed [SAMPLE_BITS-1:0] wdata,
   output logic signed [SAMPLE_BITS-1:0] rdata,
   output logic signed [SAMPLE_BITS-1:0] smooth_next
);
   import sfd_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 2;

   logic signed [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rdata_ff;
   logic        [ADDR_BITS-1:0]   wr_pos_ff;
   logic        [ADDR_BITS-1:0]   wr_pos_in;
   logic        [ADDR_BITS-1:0]   rd_addr;
   logic        [ADDR_BITS:0]     rd_diff;
   logic        [ADDR_BITS:0]     rd_wrap;
   logic signed [SAMPLE_BITS-1:0] smooth_ff;
   logic signed [SAMPLE_BITS:0]   smooth_diff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [SAMPLE_BITS+1:0] smooth_step;
   logic signed [SAMPLE_BITS+1:0] smooth_sum;

   // read address is write position minus delay, wrapped into the line
   always_comb begin
      rd_diff = {1'b0, wr_pos_ff} - {1'b0, delay};
      rd_wrap = rd_diff + (ADDR_BITS+1)'(LINE_DEPTH);
      rd_addr = rd_diff[ADDR_BITS] ? rd_wrap[ADDR_BITS-1:0] : rd_diff[ADDR_BITS-1:0];
   end

   // pointer advance with wrap at the line length
   assign wr_pos_in = (wr_pos_ff == ADDR_BITS'(LINE_DEPTH - 1)) ? '0 : wr_pos_ff + 1'b1;

   // delay memory, one read and one write port
   always_ff @(posedge clock) begin
      if (ctrl.read_en) begin
         rdata_ff <= line_mem[rd_addr];
      end
      if (ctrl.write_en) begin
         line_mem[wr_pos_ff] <= ctrl.clear ? '0 : wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
      end else if (ctrl.write_en) begin
         wr_pos_ff <= wr_pos_in;
      end
   end

   // smoother: state += (coeff * (delayed - state)) >>> COEF_BITS
   always_comb begin
      smooth_diff = {rdata_ff[SAMPLE_BITS-1], rdata_ff} - {smooth_ff[SAMPLE_BITS-1], smooth_ff};
      prod_in     = smooth_diff * $signed({1'b0, coeff});
      smooth_step = prod_ff[PROD_BITS-1:COEF_BITS];
      smooth_sum  = {{2{smooth_ff[SAMPLE_BITS-1]}}, smooth_ff} + smooth_step;
      smooth_next = smooth_sum[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
      end else if (ctrl.smooth_en) begin
         smooth_ff <= smooth_next;
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/sfd_router.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_router
// Merges the two lanes: picks the feedback source and gain per channel by
// routing mode, scales it and adds the dry input with saturation.
// ----------------------------------------------------------------------------
module sfd_router #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 16
) (
   input  wire                           clock,
   input  sfd_pkg::lane_ctrl_type        ctrl,
   input  sfd_pkg::route_mode_type       mode,
   input  wire        [COEF_BITS-1:0]    gain_left,
   input  wire        [COEF_BITS-1:0]    gain_right,
   input  wire signed [SAMPLE_BITS-1:0]  smooth_left,
   input  wire signed [SAMPLE_BITS-1:0]  smooth_right,
   input  wire signed [SAMPLE_BITS-1:0]  dry_left,
   input  wire signed [SAMPLE_BITS-1:0]  dry_right,
   output logic signed [SAMPLE_BITS-1:0] wdata_left,
   output logic signed [SAMPLE_BITS-1:0] wdata_right
);
   import sfd_pkg::*;

   localparam int FB_BITS = SAMPLE_BITS + COEF_BITS + 1;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS:0]   mono_sum;
   logic signed [SAMPLE_BITS-1:0] mono;
   logic        [COEF_BITS:0]     gain_sum;
   logic        [COEF_BITS-1:0]   gain_mono;
   logic signed [SAMPLE_BITS-1:0] op_left_in, op_right_in;
   logic        [COEF_BITS-1:0]   gain_left_in, gain_right_in;
   logic signed [SAMPLE_BITS-1:0] op_left_ff, op_right_ff;
   logic        [COEF_BITS-1:0]   gain_left_ff, gain_right_ff;
   logic signed [FB_BITS-1:0]     fb_left_ff, fb_right_ff;
   logic signed [SAMPLE_BITS+1:0] sum_left, sum_right;

   // averaged source and gain for the mono mix
   always_comb begin
      mono_sum  = {smooth_left[SAMPLE_BITS-1], smooth_left}
                + {smooth_right[SAMPLE_BITS-1], smooth_right};
      mono      = mono_sum[SAMPLE_BITS:1];
      gain_sum  = {1'b0, gain_left} + {1'b0, gain_right};
      gain_mono = gain_sum[COEF_BITS:1];
   end

   // feedback source per channel
   always_comb begin
      unique case (mode)
         ROUTE_CROSS: begin
            op_left_in    = smooth_right;
            gain_left_in  = gain_right;
            op_right_in   = smooth_left;
            gain_right_in = gain_left;
         end
         ROUTE_MONO: begin
            op_left_in    = mono;
            gain_left_in  = gain_mono;
            op_right_in   = mono;
            gain_right_in = gain_mono;
         end
         ROUTE_PING_PONG: begin
            op_left_in    = smooth_left;
            gain_left_in  = gain_left;
            op_right_in   = smooth_right;
            gain_right_in = '0;
         end
         default: begin
            op_left_in    = smooth_left;
            gain_left_in  = gain_left;
            op_right_in   = smooth_right;
            gain_right_in = gain_right;
         end
      endcase
   end

   // operand latch, then one multiply per channel
   always_ff @(posedge clock) begin
      if (ctrl.smooth_en) begin
         op_left_ff    <= op_left_in;
         op_right_ff   <= op_right_in;
         gain_left_ff  <= gain_left_in;
         gain_right_ff <= gain_right_in;
      end
      if (ctrl.feed_en) begin
         fb_left_ff  <= op_left_ff * $signed({1'b0, gain_left_ff});
         fb_right_ff <= op_right_ff * $signed({1'b0, gain_right_ff});
      end
   end

   // dry plus scaled feedback, saturated
   always_comb begin
      sum_left  = {{2{dry_left[SAMPLE_BITS-1]}}, dry_left}
                + {fb_left_ff[FB_BITS-1], fb_left_ff[FB_BITS-1:COEF_BITS]};
      sum_right = {{2{dry_right[SAMPLE_BITS-1]}}, dry_right}
                + {fb_right_ff[FB_BITS-1], fb_right_ff[FB_BITS-1:COEF_BITS]};

      if (sum_left[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b000
          || sum_left[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b111) begin
         wdata_left = sum_left[SAMPLE_BITS-1:0];
      end else begin
         wdata_left = sum_left[SAMPLE_BITS+1] ? SAMPLE_MIN : SAMPLE_MAX;
      end

      if (sum_right[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b000
          || sum_right[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b111) begin
         wdata_right = sum_right[SAMPLE_BITS-1:0];
      end else begin
         wdata_right = sum_right[SAMPLE_BITS+1] ? SAMPLE_MIN : SAMPLE_MAX;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/stereo_feedback_delay_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core
// Fully wet stereo feedback delay with stereo, cross, mono and ping-pong
// feedback routing. Two delay lanes run side by side; a router merges them.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one request per stereo pair: tdata holds sample_left in the
//   low SAMPLE_BITS and sample_right above it. rsp_* returns the delayed pair
//   in the same layout. csr_* writes one register per handshake (index 0 to
//   5); csr_ready is always high, unknown indexes are dropped.
//   A request is taken in the idle state only. After it is accepted the pair
//   passes the states MUL, SMOOTH, FEED and WRITE, and its result is then
//   registered onto rsp_*; a new pair is taken only after that write back. The
//   steps: memory read, smoothing multiply, smoother update, feedback multiply, write back.
//   While rsp_tvalid waits for rsp_tready a new request is still taken; only
//   the write back of that next pair waits until the output register frees.
//   After reset both delay lines are zeroed by a clearing pass over all
//   LINE_DEPTH entries, one entry per cycle, during which req_tready stays low;
//   configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_core #(
   parameter int LINE_DEPTH  = 131072,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 16,
   localparam int DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int CSR_BITS   = (COEF_BITS > sfd_pkg::DELAY_BITS) ? COEF_BITS
                                                                  : sfd_pkg::DELAY_BITS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // sample_left, sample_right (low bits up)
   input  wire  [DATA_BITS-1:0]                 req_tdata,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // delayed_left, delayed_right (low bits up)
   output logic [DATA_BITS-1:0]                 rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [sfd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [CSR_BITS-1:0]                  csr_wdata
);
   import sfd_pkg::*;

   localparam int ADDR_BITS = $clog2(LINE_DEPTH);
   localparam int DELAY_MAX = (1 << DELAY_BITS) - 1;
   localparam int RED_MAX   = 8;
   localparam int RED_STEPS = (LINE_DEPTH > DELAY_MAX) ? 0
                            : $clog2(DELAY_MAX / LINE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SMOOTH,
      ST_FEED,
      ST_WRITE
   } state_type;

   // delay modulo line length, by shifted compare and subtract
   function automatic logic [ADDR_BITS-1:0] reduce_delay(input logic [DELAY_BITS-1:0] d);
      logic [31:0] r;
      r = 32'(d);
      for (int k = RED_MAX - 1; k >= 0; k--) begin
         if (k < RED_STEPS && r >= (32'(LINE_DEPTH) << k)) begin
            r = r - (32'(LINE_DEPTH) << k);
         end
      end
      return r[ADDR_BITS-1:0];
   endfunction

   state_type                     state_ff;
   logic [ADDR_BITS-1:0]          clear_cnt_ff;
   logic [ADDR_BITS-1:0]          delay_left_ff, delay_right_ff;
   logic [COEF_BITS-1:0]          coeff_ff, fb_left_ff, fb_right_ff;
   route_mode_type                mode_ff;
   logic signed [SAMPLE_BITS-1:0] dry_left_ff, dry_right_ff;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_right_ff;
   logic                          rsp_valid_ff;
   logic                          req_fire, csr_fire, out_free;
   lane_ctrl_type                 ctrl;
   logic signed [SAMPLE_BITS-1:0] rdata_left, rdata_right;
   logic signed [SAMPLE_BITS-1:0] smooth_left, smooth_right;
   logic signed [SAMPLE_BITS-1:0] wdata_left, wdata_right;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid & csr_ready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_left_ff  <= reduce_delay(DELAY_BITS'(1));
         delay_right_ff <= reduce_delay(DELAY_BITS'(1));
         coeff_ff       <= COEF_BITS'(32'd32768);
         fb_left_ff     <= '0;
         fb_right_ff    <= '0;
         mode_ff        <= ROUTE_STEREO;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_DELAY_LEFT:     delay_left_ff  <= reduce_delay(csr_wdata[DELAY_BITS-1:0]);
            CSR_DELAY_RIGHT:    delay_right_ff <= reduce_delay(csr_wdata[DELAY_BITS-1:0]);
            CSR_SMOOTH_COEFF:   coeff_ff       <= csr_wdata[COEF_BITS-1:0];
            CSR_FEEDBACK_LEFT:  fb_left_ff     <= csr_wdata[COEF_BITS-1:0];
            CSR_FEEDBACK_RIGHT: fb_right_ff    <= csr_wdata[COEF_BITS-1:0];
            CSR_ROUTE_MODE:     mode_ff        <= route_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // lane and router strobes
   always_comb begin
      ctrl.read_en   = req_fire;
      ctrl.prod_en   = (state_ff == ST_MUL);
      ctrl.smooth_en = (state_ff == ST_SMOOTH);
      ctrl.feed_en   = (state_ff == ST_FEED);
      ctrl.clear     = (state_ff == ST_CLEAR);
      ctrl.write_en  = ctrl.clear | ((state_ff == ST_WRITE) & out_free);
   end

   // item sequencer with clearing pass and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a taken result empties the output unless the next one loads now
         if (rsp_valid_ff && rsp_tready && state_ff != ST_WRITE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clear_cnt_ff <= clear_cnt_ff + 1'b1;
               if (clear_cnt_ff == ADDR_BITS'(LINE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  dry_left_ff  <= req_tdata[SAMPLE_BITS-1:0];
                  dry_right_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                  state_ff     <= ST_MUL;
               end
            end
            ST_MUL:    state_ff <= ST_SMOOTH;
            ST_SMOOTH: state_ff <= ST_FEED;
            ST_FEED:   state_ff <= ST_WRITE;
            ST_WRITE: begin
               if (out_free) begin
                  out_left_ff  <= rdata_left;
                  out_right_ff <= rdata_right;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'({out_right_ff, out_left_ff});

   // left lane
   sfd_lane #(
      .LINE_DEPTH  (LINE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_lane_left (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .delay       (delay_left_ff),
      .coeff       (coeff_ff),
      .wdata       (wdata_left),
      .rdata       (rdata_left),
      .smooth_next (smooth_left)
   );

   // right lane
   sfd_lane #(
      .LINE_DEPTH  (LINE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .delay       (delay_right_ff),
      .coeff       (coeff_ff),
      .wdata       (wdata_right),
      .rdata       (rdata_right),
      .smooth_next (smooth_right)
   );

   // feedback routing and write back values
   sfd_router #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_router (
      .clock        (clock),
      .ctrl         (ctrl),
      .mode         (mode_ff),
      .gain_left    (fb_left_ff),
      .gain_right   (fb_right_ff),
      .smooth_left  (smooth_left),
      .smooth_right (smooth_right),
      .dry_left     (dry_left_ff),
      .dry_right    (dry_right_ff),
      .wdata_left   (wdata_left),
      .wdata_right  (wdata_right)
   );

endmodule
`default_nettype wire
